>>> rtl/core/mna_stamp_accumulator_core_defines.svh
// assertion macros used by the core sequencer (msa_ctrl)
`ifndef MNA_STAMP_ACCUMULATOR_CORE_DEFINES_SVH
`define MNA_STAMP_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("msa assertion failed");

// next-cycle implication, disabled while in reset
`define MSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("msa assertion failed");

`endif

>>> rtl/core/msa_pkg.sv
package msa_pkg;

    localparam int MatrixDimDefault     = 32;
    localparam int ValueFracBitsDefault = 16;
    localparam int EntryW               = 48;
    localparam int ValueW               = 32;
    localparam int FieldW               = 6;
    localparam int OpW                  = 4;
    localparam int StepW                = 3;

    // opcodes
    localparam logic [OpW-1:0] OP_RD_MAT = 4'd0;
    localparam logic [OpW-1:0] OP_RD_RHS = 4'd1;
    localparam logic [OpW-1:0] OP_RES    = 4'd2;
    localparam logic [OpW-1:0] OP_ISRC   = 4'd3;
    localparam logic [OpW-1:0] OP_VSRC   = 4'd4;
    localparam logic [OpW-1:0] OP_VCVS   = 4'd5;
    localparam logic [OpW-1:0] OP_CCVS   = 4'd6;
    localparam logic [OpW-1:0] OP_CCCS   = 4'd7;
    localparam logic [OpW-1:0] OP_VCCS   = 4'd8;

    // result status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_RANGE  = 2'd1;
    localparam logic [1:0] STS_ZERO_R = 2'd2;
    localparam logic [1:0] STS_SAT    = 2'd3;

    typedef struct packed {
        logic [OpW-1:0]           opcode;
        logic                     extra_current_group;
        logic [FieldW-1:0]        pos_node;
        logic [FieldW-1:0]        neg_node;
        logic [FieldW-1:0]        ctrl_plus;
        logic [FieldW-1:0]        ctrl_minus;
        logic [FieldW-1:0]        branch_row;
        logic [FieldW-1:0]        ctrl_branch_row;
        logic signed [ValueW-1:0] elem_val;
        logic [FieldW-1:0]        read_row;
        logic [FieldW-1:0]        read_col;
    } msa_in_t;

    typedef struct packed {
        logic signed [EntryW-1:0] read_data;
        logic [1:0]               status;
    } msa_out_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_RD, S_WR, S_FIN
    } msa_state_t;

    // which item field gives a row or column
    typedef enum logic [2:0] {
        SEL_NP, SEL_NM, SEL_BR, SEL_CP, SEL_CM, SEL_CBR
    } msa_sel_t;

    // which value is added
    typedef enum logic [2:0] {
        DLT_ONE, DLT_NONE, DLT_V, DLT_NV, DLT_G, DLT_NG
    } msa_dlt_t;

    typedef struct packed {
        logic     vec;
        msa_sel_t row;
        msa_sel_t col;
        msa_dlt_t dlt;
    } msa_step_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic div_start;
        logic rd;
        logic wr;
        logic finish;
    } msa_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       is_read;
        logic [1:0] err;
        logic       need_div;
        logic       div_done;
        logic       last_step;
    } msa_sts_t;

    function automatic msa_step_t mk(input logic vec, input msa_sel_t row,
                                     input msa_sel_t col, input msa_dlt_t dlt);
        msa_step_t s;
        s.vec = vec;
        s.row = row;
        s.col = col;
        s.dlt = dlt;
        return s;
    endfunction

    // symmetric incidence entries, steps 0 to 3
    function automatic msa_step_t inc_step(input logic [StepW-1:0] step);
        msa_step_t s;
        case (step)
            3'd0:    s = mk(1'b0, SEL_NP, SEL_BR, DLT_ONE);
            3'd1:    s = mk(1'b0, SEL_NM, SEL_BR, DLT_NONE);
            3'd2:    s = mk(1'b0, SEL_BR, SEL_NP, DLT_ONE);
            default: s = mk(1'b0, SEL_BR, SEL_NM, DLT_NONE);
        endcase
        return s;
    endfunction

    // node column entries plus the branch diagonal, steps 0 to 2
    function automatic msa_step_t col_step(input logic [StepW-1:0] step);
        msa_step_t s;
        case (step)
            3'd0:    s = mk(1'b0, SEL_NP, SEL_BR, DLT_ONE);
            3'd1:    s = mk(1'b0, SEL_NM, SEL_BR, DLT_NONE);
            default: s = mk(1'b0, SEL_BR, SEL_BR, DLT_ONE);
        endcase
        return s;
    endfunction

    // one read-modify-write of a stamp
    function automatic msa_step_t step_op(input logic [OpW-1:0] op, input logic g2,
                                          input logic [StepW-1:0] step);
        msa_step_t s;
        s = mk(1'b0, SEL_NP, SEL_NP, DLT_ONE);
        case (op)
            OP_RES: begin
                if (!g2) begin
                    case (step)
                        3'd0:    s = mk(1'b0, SEL_NP, SEL_NP, DLT_G);
                        3'd1:    s = mk(1'b0, SEL_NP, SEL_NM, DLT_NG);
                        3'd2:    s = mk(1'b0, SEL_NM, SEL_NM, DLT_G);
                        default: s = mk(1'b0, SEL_NM, SEL_NP, DLT_NG);
                    endcase
                end else if (step < 3'd4) begin
                    s = inc_step(step);
                end else begin
                    s = mk(1'b0, SEL_BR, SEL_BR, DLT_NV);
                end
            end
            OP_ISRC: begin
                if (!g2) begin
                    s = (step == 3'd0) ? mk(1'b1, SEL_NP, SEL_NP, DLT_NV)
                                       : mk(1'b1, SEL_NM, SEL_NM, DLT_V);
                end else if (step < 3'd3) begin
                    s = col_step(step);
                end else begin
                    s = mk(1'b1, SEL_BR, SEL_BR, DLT_V);
                end
            end
            OP_VSRC: begin
                s = (step < 3'd4) ? inc_step(step) : mk(1'b1, SEL_BR, SEL_BR, DLT_V);
            end
            OP_VCVS: begin
                if (step < 3'd4) begin
                    s = inc_step(step);
                end else if (step == 3'd4) begin
                    s = mk(1'b0, SEL_BR, SEL_CP, DLT_NV);
                end else begin
                    s = mk(1'b0, SEL_BR, SEL_CM, DLT_V);
                end
            end
            OP_CCVS: begin
                s = (step < 3'd4) ? inc_step(step) : mk(1'b0, SEL_BR, SEL_CBR, DLT_NV);
            end
            OP_CCCS: begin
                if (!g2) begin
                    s = (step == 3'd0) ? mk(1'b0, SEL_NP, SEL_CBR, DLT_V)
                                       : mk(1'b0, SEL_NM, SEL_CBR, DLT_NV);
                end else if (step < 3'd3) begin
                    s = col_step(step);
                end else begin
                    s = mk(1'b0, SEL_BR, SEL_CBR, DLT_NV);
                end
            end
            OP_VCCS: begin
                if (!g2) begin
                    case (step)
                        3'd0:    s = mk(1'b0, SEL_NP, SEL_CP, DLT_V);
                        3'd1:    s = mk(1'b0, SEL_NP, SEL_CM, DLT_NV);
                        3'd2:    s = mk(1'b0, SEL_NM, SEL_CP, DLT_NV);
                        default: s = mk(1'b0, SEL_NM, SEL_CM, DLT_V);
                    endcase
                end else begin
                    case (step)
                        3'd0:    s = mk(1'b0, SEL_NP, SEL_BR, DLT_ONE);
                        3'd1:    s = mk(1'b0, SEL_NM, SEL_BR, DLT_NONE);
                        3'd2:    s = mk(1'b0, SEL_BR, SEL_CP, DLT_NV);
                        3'd3:    s = mk(1'b0, SEL_BR, SEL_CM, DLT_V);
                        default: s = mk(1'b0, SEL_BR, SEL_BR, DLT_ONE);
                    endcase
                end
            end
            default: s = mk(1'b0, SEL_NP, SEL_NP, DLT_ONE);
        endcase
        return s;
    endfunction

    // number of read-modify-writes of a stamp
    function automatic logic [StepW-1:0] step_count(input logic [OpW-1:0] op,
                                                    input logic g2);
        logic [StepW-1:0] n;
        case (op)
            OP_RES:  n = g2 ? 3'd5 : 3'd4;
            OP_ISRC: n = g2 ? 3'd4 : 3'd2;
            OP_VSRC: n = 3'd5;
            OP_VCVS: n = 3'd6;
            OP_CCVS: n = 3'd5;
            OP_CCCS: n = g2 ? 3'd4 : 3'd2;
            OP_VCCS: n = g2 ? 3'd5 : 3'd4;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/msa_div.sv
module msa_div #(
    parameter int VALUE_FRAC_BITS = msa_pkg::ValueFracBitsDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [31:0]                   divisor,
    output logic [2*VALUE_FRAC_BITS:0]    quotient,
    output logic                          done
);
    localparam int NB = 2 * VALUE_FRAC_BITS + 1;
    localparam int CW = $clog2(NB);

    logic [32:0]   rem_reg, rem_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic [32:0]   trial;
    logic          qbit;

    // one quotient bit per cycle, dividend is a single one at bit 2*frac
    always_comb begin
        trial     = {rem_reg[31:0], (32'(idx_reg) == 32'(NB - 1))};
        qbit      = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = '0;
            idx_next  = CW'(NB - 1);
            busy_next = 1'b1;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = qbit ? (trial - {1'b0, dvs_reg}) : trial;
            quo_next = {quo_reg[NB-2:0], qbit};
            idx_next = idx_reg - CW'(1);
            if (idx_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        idx_reg <= idx_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/msa_dp.sv
module msa_dp #(
    parameter int MATRIX_DIM      = msa_pkg::MatrixDimDefault,
    parameter int VALUE_FRAC_BITS = msa_pkg::ValueFracBitsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  msa_pkg::msa_in_t  s_data,
    input  msa_pkg::msa_cmd_t cmd,
    output msa_pkg::msa_sts_t sts,
    output msa_pkg::msa_out_t m_data
);
    import msa_pkg::*;

    localparam int IW = $clog2(MATRIX_DIM);
    localparam int NE = MATRIX_DIM * MATRIX_DIM;
    localparam int AW = $clog2(NE);
    localparam int NB = 2 * VALUE_FRAC_BITS + 1;
    localparam logic [EntryW-1:0] OneFx    = EntryW'(1) << VALUE_FRAC_BITS;
    localparam logic [EntryW-1:0] EntryMax = {1'b0, {(EntryW-1){1'b1}}};
    localparam logic [EntryW-1:0] EntryMin = {1'b1, {(EntryW-1){1'b0}}};

    logic [EntryW-1:0] mat_mem [NE];
    logic [EntryW-1:0] rhs_mem [MATRIX_DIM];

    msa_in_t           item_reg;
    logic [StepW-1:0]  step_reg;
    logic [AW-1:0]     clr_reg;
    logic [EntryW-1:0] g_reg, g_next;
    logic              sat_reg, sat_next;
    logic [EntryW-1:0] mat_q_reg, rhs_q_reg;
    msa_out_t          out_reg;

    msa_step_t         st;
    logic              is_read, g2;
    logic [FieldW-1:0] row_f, col_f;
    logic              skip;
    logic [AW-1:0]     addr;
    logic [IW-1:0]     ridx;
    logic [EntryW-1:0] v48, delta, cur;
    logic [EntryW:0]   sum;
    logic              ovf;
    logic [EntryW-1:0] wval;
    logic [1:0]        err;
    logic [31:0]       vmag;
    logic [NB-1:0]     quo;
    logic              div_done;
    logic [63:0]       q64;
    msa_out_t          res;

    function automatic logic node_ok(input logic [FieldW-1:0] n);
        return int'(n) <= MATRIX_DIM;
    endfunction

    function automatic logic row_ok(input logic [FieldW-1:0] r);
        return (r != '0) && (int'(r) <= MATRIX_DIM);
    endfunction

    function automatic logic [FieldW-1:0] pick(input msa_sel_t sel, input msa_in_t it);
        logic [FieldW-1:0] f;
        case (sel)
            SEL_NP:  f = it.pos_node;
            SEL_NM:  f = it.neg_node;
            SEL_BR:  f = it.branch_row;
            SEL_CP:  f = it.ctrl_plus;
            SEL_CM:  f = it.ctrl_minus;
            SEL_CBR: f = it.ctrl_branch_row;
            default: f = it.pos_node;
        endcase
        return f;
    endfunction

    // item checks
    always_comb begin
        logic need_br, need_c, need_cbr;
        logic [OpW-1:0] op;
        op       = item_reg.opcode;
        g2       = item_reg.extra_current_group;
        is_read  = (op == OP_RD_MAT) || (op == OP_RD_RHS);
        need_br  = (op == OP_VSRC) || (op == OP_VCVS) || (op == OP_CCVS) || g2;
        need_c   = (op == OP_VCVS) || (op == OP_VCCS);
        need_cbr = (op == OP_CCVS) || (op == OP_CCCS);
        err      = STS_OK;
        if (is_read) begin
            if (!row_ok(item_reg.read_row) ||
                ((op == OP_RD_MAT) && !row_ok(item_reg.read_col))) begin
                err = STS_RANGE;
            end
        end else if (op > OP_VCCS) begin
            err = STS_RANGE;
        end else if (!node_ok(item_reg.pos_node) || !node_ok(item_reg.neg_node) ||
                     (need_br && !row_ok(item_reg.branch_row)) ||
                     (need_c && (!node_ok(item_reg.ctrl_plus) ||
                                 !node_ok(item_reg.ctrl_minus))) ||
                     (need_cbr && !row_ok(item_reg.ctrl_branch_row))) begin
            err = STS_RANGE;
        end else if ((op == OP_RES) && !g2 && (item_reg.elem_val == '0)) begin
            err = STS_ZERO_R;
        end
    end

    // entry address of the current step or read
    always_comb begin
        st = step_op(item_reg.opcode, g2, step_reg);
        if (is_read) begin
            row_f = item_reg.read_row;
            col_f = item_reg.read_col;
        end else begin
            row_f = pick(st.row, item_reg);
            col_f = pick(st.col, item_reg);
        end
        skip = (row_f == '0) || (int'(row_f) > MATRIX_DIM) ||
               (!st.vec && ((col_f == '0) || (int'(col_f) > MATRIX_DIM)));
        addr = AW'(AW'(row_f - 6'd1) * AW'(MATRIX_DIM)) + AW'(col_f - 6'd1);
        ridx = IW'(row_f - 6'd1);
    end

    // value added and saturating sum
    always_comb begin
        v48 = {{(EntryW-ValueW){item_reg.elem_val[ValueW-1]}},
               item_reg.elem_val};
        case (st.dlt)
            DLT_ONE:  delta = OneFx;
            DLT_NONE: delta = -OneFx;
            DLT_V:    delta = v48;
            DLT_NV:   delta = -v48;
            DLT_G:    delta = g_reg;
            DLT_NG:   delta = -g_reg;
            default:  delta = '0;
        endcase
        cur  = st.vec ? rhs_q_reg : mat_q_reg;
        sum  = {cur[EntryW-1], cur} + {delta[EntryW-1], delta};
        ovf  = sum[EntryW] != sum[EntryW-1];
        wval = ovf ? (sum[EntryW] ? EntryMin : EntryMax) : sum[EntryW-1:0];
    end

    // conductance from the quotient, saturated
    assign vmag = item_reg.elem_val[ValueW-1] ? (~item_reg.elem_val + 32'd1)
                                              : item_reg.elem_val;
    assign q64  = 64'(quo);

    always_comb begin
        g_next   = g_reg;
        sat_next = sat_reg;
        if (cmd.load) begin
            sat_next = 1'b0;
        end else if (div_done) begin
            if (!item_reg.elem_val[ValueW-1]) begin
                if (q64 > 64'(EntryMax)) begin
                    g_next   = EntryMax;
                    sat_next = 1'b1;
                end else begin
                    g_next = q64[EntryW-1:0];
                end
            end else begin
                if (q64 > 64'(EntryMax) + 64'd1) begin
                    g_next   = EntryMin;
                    sat_next = 1'b1;
                end else begin
                    g_next = -q64[EntryW-1:0];
                end
            end
        end else if (cmd.wr && !skip && ovf) begin
            sat_next = 1'b1;
        end
    end

    msa_div #(
        .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (vmag),
        .quotient(quo),
        .done    (div_done)
    );

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            step_reg <= '0;
            sat_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.load) begin
                step_reg <= '0;
            end else if (cmd.wr) begin
                step_reg <= step_reg + StepW'(1);
            end
            sat_reg <= sat_next;
        end
    end

    // item and conductance registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        g_reg <= g_next;
    end

    // matrix store
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mat_mem[clr_reg] <= '0;
        end else if (cmd.wr && !skip && !st.vec) begin
            mat_mem[addr] <= wval;
        end
        if (cmd.rd) begin
            mat_q_reg <= mat_mem[addr];
        end
    end

    // right-hand-side store
    always_ff @(posedge aclk) begin
        if (cmd.clear && (int'(clr_reg) < MATRIX_DIM)) begin
            rhs_mem[IW'(clr_reg)] <= '0;
        end else if (cmd.wr && !skip && st.vec) begin
            rhs_mem[ridx] <= wval;
        end
        if (cmd.rd) begin
            rhs_q_reg <= rhs_mem[ridx];
        end
    end

    // result
    always_comb begin
        res.read_data = '0;
        res.status    = err;
        if (err == STS_OK) begin
            if (is_read) begin
                res.read_data = (item_reg.opcode == OP_RD_MAT) ? mat_q_reg : rhs_q_reg;
            end else if (sat_reg) begin
                res.status = STS_SAT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= res;
        end
    end

    assign m_data         = out_reg;
    assign sts.clear_last = int'(clr_reg) == NE - 1;
    assign sts.is_read    = is_read;
    assign sts.err        = err;
    assign sts.need_div   = (item_reg.opcode == OP_RES) && !g2;
    assign sts.div_done   = div_done;
    assign sts.last_step  = step_reg == (step_count(item_reg.opcode, g2) - StepW'(1));

endmodule

>>> rtl/core/msa_ctrl.sv
`include "mna_stamp_accumulator_core_defines.svh"

module msa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  msa_pkg::msa_sts_t sts,
    output msa_pkg::msa_cmd_t cmd
);
    import msa_pkg::*;

    msa_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
            S_IDLE:  if (s_valid) state_next = S_CHECK;
            S_CHECK: begin
                if (sts.err != STS_OK) begin
                    state_next = S_FIN;
                end else if (sts.need_div) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DIV:   if (sts.div_done) state_next = S_RD;
            S_RD:    state_next = sts.is_read ? S_FIN : S_WR;
            S_WR:    state_next = sts.last_step ? S_FIN : S_RD;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd           = '0;
        cmd.clear     = state_reg == S_CLEAR;
        cmd.load      = (state_reg == S_IDLE) && s_valid;
        cmd.div_start = (state_reg == S_CHECK) && (sts.err == STS_OK) && sts.need_div;
        cmd.rd        = state_reg == S_RD;
        cmd.wr        = state_reg == S_WR;
        cmd.finish    = (state_reg == S_FIN) && out_free;
    end

    // result register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;

    `MSA_ASSERT_IMP(a_clear_blocks, aclk, aresetn, state_reg == S_CLEAR, !s_ready)
    `MSA_ASSERT_NXT(a_rd_then_wr, aclk, aresetn, cmd.rd && !sts.is_read, state_reg == S_WR)
    `MSA_ASSERT_NXT(a_finish_valid, aclk, aresetn, cmd.finish, out_valid_reg)
    `MSA_ASSERT_NXT(a_div_wait, aclk, aresetn, cmd.div_start, state_reg == S_DIV)
    `MSA_ASSERT_IMP(a_wr_stamp_only, aclk, aresetn, cmd.wr, !sts.is_read)

endmodule

>>> rtl/core/mna_stamp_accumulator_core.sv
// Modified-nodal-analysis stamping engine: each item is one circuit element, whose
// stamp is added into a stored MATRIX_DIM x MATRIX_DIM matrix and right-hand-side
// vector with saturating Q32.16 arithmetic, or a read request that returns one entry.
// One item is handled at a time; a result waiting in the output register does not
// block acceptance of the next item. A stamp is applied as n read-modify-writes
// (two to six, one memory port pass each); a group-one resistor first has its
// conductance worked out by the bit-serial reciprocal. After reset a clearing pass
// over all MATRIX_DIM*MATRIX_DIM entries (1024 by default) zeroes the store, and no
// item is accepted until it ends.
module mna_stamp_accumulator_core #(
    parameter int MATRIX_DIM      = msa_pkg::MatrixDimDefault,
    parameter int VALUE_FRAC_BITS = msa_pkg::ValueFracBitsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  msa_pkg::msa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output msa_pkg::msa_out_t m_data
);
    import msa_pkg::*;

    msa_cmd_t cmd;
    msa_sts_t sts;

    // sequencer
    msa_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // store, arithmetic and result register
    msa_dp #(
        .MATRIX_DIM     (MATRIX_DIM),
        .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

endmodule

>>> test/tb_mna_stamp_accumulator_core.sv
`timescale 1ns / 1ps

module tb_mna_stamp_accumulator_core;
    import msa_pkg::*;

    localparam int DIM = MatrixDimDefault;
    localparam int FRAC = ValueFracBitsDefault;
    localparam longint ENT_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint ENT_MIN = -ENT_MAX - 1;
    localparam longint ONE_FX = 64'sd1 <<< FRAC;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    msa_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    msa_out_t m_data;

    // shadow copy of the stored system
    longint mat_shadow [DIM*DIM];
    longint rhs_shadow [DIM];
    bit sat_flag;

    msa_in_t pending_items [$];
    msa_out_t expected_results [$];
    bit failed = 1'b0;
    bit hold_sender = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int idle_cycles = 0;

    mna_stamp_accumulator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    function automatic longint clamp_entry(input longint v);
        if (v > ENT_MAX) begin sat_flag = 1'b1; return ENT_MAX; end
        if (v < ENT_MIN) begin sat_flag = 1'b1; return ENT_MIN; end
        return v;
    endfunction

    function automatic void add_entry(input int r, input int c, input longint d);
        int i;
        if (r == 0 || c == 0 || r > DIM || c > DIM) return;
        i = (r - 1) * DIM + (c - 1);
        mat_shadow[i] = clamp_entry(mat_shadow[i] + d);
    endfunction

    function automatic void add_rhs(input int r, input longint d);
        if (r == 0 || r > DIM) return;
        rhs_shadow[r-1] = clamp_entry(rhs_shadow[r-1] + d);
    endfunction

    function automatic void add_incidence(input int np, input int nm, input int br,
                                          input bit both);
        add_entry(np, br, ONE_FX);
        add_entry(nm, br, -ONE_FX);
        if (both) begin
            add_entry(br, np, ONE_FX);
            add_entry(br, nm, -ONE_FX);
        end
    endfunction

    // apply one element to the shadow system and work out its result
    function automatic msa_out_t stamp_element(input msa_in_t it);
        msa_out_t res;
        int np, nm, cp, cm, br, cbr, rr, rc;
        longint v, g;
        bit g2, need_br, need_c, need_cbr;
        np = int'(it.pos_node); nm = int'(it.neg_node);
        cp = int'(it.ctrl_plus); cm = int'(it.ctrl_minus);
        br = int'(it.branch_row); cbr = int'(it.ctrl_branch_row);
        rr = int'(it.read_row); rc = int'(it.read_col);
        v = longint'(it.elem_val);
        g2 = it.extra_current_group;
        res = '0;
        sat_flag = 1'b0;
        if (it.opcode == OP_RD_MAT || it.opcode == OP_RD_RHS) begin
            if (rr < 1 || rr > DIM || (it.opcode == OP_RD_MAT && (rc < 1 || rc > DIM)))
                res.status = STS_RANGE;
            else if (it.opcode == OP_RD_MAT)
                res.read_data = EntryW'(mat_shadow[(rr-1)*DIM + rc-1]);
            else
                res.read_data = EntryW'(rhs_shadow[rr-1]);
            return res;
        end
        if (it.opcode > OP_VCCS) begin
            res.status = STS_RANGE;
            return res;
        end
        need_br = it.opcode inside {OP_VSRC, OP_VCVS, OP_CCVS} || g2;
        need_c = it.opcode inside {OP_VCVS, OP_VCCS};
        need_cbr = it.opcode inside {OP_CCVS, OP_CCCS};
        if (np > DIM || nm > DIM || (need_br && (br < 1 || br > DIM))
            || (need_c && (cp > DIM || cm > DIM))
            || (need_cbr && (cbr < 1 || cbr > DIM))) begin
            res.status = STS_RANGE;
            return res;
        end
        case (it.opcode)
            OP_RES: begin
                if (!g2) begin
                    if (v == 0) begin
                        res.status = STS_ZERO_R;
                        return res;
                    end
                    g = clamp_entry((64'sd1 <<< (2*FRAC)) / v);
                    add_entry(np, np, g);
                    add_entry(np, nm, -g);
                    add_entry(nm, nm, g);
                    add_entry(nm, np, -g);
                end else begin
                    add_incidence(np, nm, br, 1'b1);
                    add_entry(br, br, -v);
                end
            end
            OP_ISRC: begin
                if (!g2) begin
                    add_rhs(np, -v);
                    add_rhs(nm, v);
                end else begin
                    add_incidence(np, nm, br, 1'b0);
                    add_entry(br, br, ONE_FX);
                    add_rhs(br, v);
                end
            end
            OP_VSRC: begin
                add_incidence(np, nm, br, 1'b1);
                add_rhs(br, v);
            end
            OP_VCVS: begin
                add_incidence(np, nm, br, 1'b1);
                add_entry(br, cp, -v);
                add_entry(br, cm, v);
            end
            OP_CCVS: begin
                add_incidence(np, nm, br, 1'b1);
                add_entry(br, cbr, -v);
            end
            OP_CCCS: begin
                if (!g2) begin
                    add_entry(np, cbr, v);
                    add_entry(nm, cbr, -v);
                end else begin
                    add_incidence(np, nm, br, 1'b0);
                    add_entry(br, br, ONE_FX);
                    add_entry(br, cbr, -v);
                end
            end
            default: begin
                if (!g2) begin
                    if (np != 0) begin add_entry(np, cp, v); add_entry(np, cm, -v); end
                    if (nm != 0) begin add_entry(nm, cp, -v); add_entry(nm, cm, v); end
                end else begin
                    add_incidence(np, nm, br, 1'b0);
                    add_entry(br, cp, -v);
                    add_entry(br, cm, v);
                    add_entry(br, br, ONE_FX);
                end
            end
        endcase
        res.status = sat_flag ? STS_SAT : STS_OK;
        return res;
    endfunction

    // node or row index, mostly in range, sometimes ground or beyond
    function automatic logic [FieldW-1:0] pick_index();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 6) return '0;
        if (p < 11) return FieldW'($urandom_range(DIM + 1, 63));
        if (p < 20) return FieldW'(DIM);
        return FieldW'($urandom_range(1, 8));
    endfunction

    function automatic logic [31:0] pick_value();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 8) return 32'h7FFF_FFFF;
        if (p < 16) return 32'h8000_0000;
        if (p < 20) return '0;
        if (p < 30) return $urandom_range(1, 16);
        if (p < 60) return $urandom;
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    function automatic msa_in_t random_item();
        msa_in_t it;
        int p;
        it.opcode = $urandom_range(0, 99) < 3 ? OpW'($urandom_range(9, 15))
                                             : OpW'($urandom_range(0, 8));
        it.extra_current_group = 1'($urandom_range(0, 1));
        it.pos_node = pick_index();
        it.neg_node = pick_index();
        it.ctrl_plus = pick_index();
        it.ctrl_minus = pick_index();
        it.branch_row = pick_index();
        it.ctrl_branch_row = pick_index();
        it.elem_val = pick_value();
        p = int'($urandom_range(0, 9));
        it.read_row = p == 0 ? FieldW'($urandom_range(0, 63)) : FieldW'($urandom_range(1, 8));
        it.read_col = p == 1 ? FieldW'($urandom_range(0, 63)) : FieldW'($urandom_range(1, 8));
        return it;
    endfunction

    function automatic msa_in_t make_item(input logic [OpW-1:0] op, input bit g2,
                                          input int np, input int nm, input int cp,
                                          input int cm, input int br, input int cbr,
                                          input logic [31:0] v, input int rr,
                                          input int rc);
        msa_in_t it;
        it.opcode = op; it.extra_current_group = g2;
        it.pos_node = FieldW'(np); it.neg_node = FieldW'(nm);
        it.ctrl_plus = FieldW'(cp); it.ctrl_minus = FieldW'(cm);
        it.branch_row = FieldW'(br); it.ctrl_branch_row = FieldW'(cbr);
        it.elem_val = v; it.read_row = FieldW'(rr); it.read_col = FieldW'(rc);
        return it;
    endfunction

    // driver
    always @(posedge aclk) begin
        int gap;
        if (s_valid && s_ready) begin
            expected_results.push_back(stamp_element(s_data));
            gap = int'($urandom_range(0, 17));
            if (gap == 0 && !hold_sender && pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                send_gap <= 0;
            end else begin
                s_valid <= 1'b0;
                send_gap <= gap;
            end
        end else if (!s_valid && aresetn && !hold_sender && pending_items.size() > 0) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        msa_out_t exp_res;
        if (m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item data=%h status=%0d", $time,
                         m_data.read_data, m_data.status);
                failed = 1'b1;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_data.read_data !== exp_res.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             exp_res.read_data, m_data.read_data);
                    failed = 1'b1;
                end
                if (m_data.status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, m_data.status);
                    failed = 1'b1;
                end
            end
            recv_gap = int'($urandom_range(0, 17));
            if (recv_gap == 0) m_ready <= 1'b1;
            else m_ready <= 1'b0;
        end else if (aresetn && !m_ready) begin
            if (recv_gap > 0) recv_gap = recv_gap - 1;
            else m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** mna_stamp_accumulator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int n;
        for (int i = 0; i < DIM*DIM; i++) mat_shadow[i] = 0;
        for (int i = 0; i < DIM; i++) rhs_shadow[i] = 0;

        // directed: every operation, ground, range limits, zero resistance, extreme values
        pending_items.push_back(make_item(OP_RES, 1'b0, 1, 2, 0, 0, 1, 1, 32'h0001_0000, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b0, 1, 0, 0, 0, 1, 1, 32'h0000_0000, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b0, 33, 2, 0, 0, 1, 1, 32'h0000_0000, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b0, 3, 32, 0, 0, 1, 1, 32'h0000_0001, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b0, 3, 4, 0, 0, 1, 1, 32'h8000_0000, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b1, 1, 2, 0, 0, 32, 1, 32'h7FFF_FFFF, 1, 1));
        pending_items.push_back(make_item(OP_RES, 1'b1, 1, 2, 0, 0, 0, 1, 32'h0001_0000, 1, 1));
        pending_items.push_back(make_item(OP_ISRC, 1'b0, 1, 0, 0, 0, 0, 0, 32'hFFFF_0000, 1, 1));
        pending_items.push_back(make_item(OP_ISRC, 1'b1, 2, 3, 0, 0, 5, 0, 32'h0002_0000, 1, 1));
        pending_items.push_back(make_item(OP_VSRC, 1'b0, 1, 0, 0, 0, 6, 0, 32'h7FFF_FFFF, 1, 1));
        pending_items.push_back(make_item(OP_VCVS, 1'b1, 2, 1, 3, 4, 7, 0, 32'h0003_0000, 1, 1));
        pending_items.push_back(make_item(OP_VCVS, 1'b0, 2, 1, 33, 4, 7, 0, 32'h0003_0000, 1, 1));
        pending_items.push_back(make_item(OP_CCVS, 1'b0, 1, 2, 0, 0, 8, 6, 32'h8000_0000, 1, 1));
        pending_items.push_back(make_item(OP_CCCS, 1'b0, 1, 2, 0, 0, 0, 6, 32'h0000_8000, 1, 1));
        pending_items.push_back(make_item(OP_CCCS, 1'b1, 1, 2, 0, 0, 9, 63, 32'h0000_8000, 1, 1));
        pending_items.push_back(make_item(OP_CCCS, 1'b1, 1, 2, 0, 0, 9, 6, 32'h0000_8000, 1, 1));
        pending_items.push_back(make_item(OP_VCCS, 1'b0, 0, 2, 3, 0, 0, 0, 32'h0001_0000, 1, 1));
        pending_items.push_back(make_item(OP_VCCS, 1'b1, 1, 2, 3, 4, 10, 0, 32'h0001_0000, 1, 1));
        pending_items.push_back(make_item(4'd15, 1'b1, 63, 63, 63, 63, 63, 63, 32'hFFFF_FFFF,
                                          63, 63));
        pending_items.push_back(make_item(OP_RD_MAT, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 1, 1));
        pending_items.push_back(make_item(OP_RD_MAT, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 32, 32));
        pending_items.push_back(make_item(OP_RD_MAT, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 0, 1));
        pending_items.push_back(make_item(OP_RD_MAT, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 6, 33));
        pending_items.push_back(make_item(OP_RD_RHS, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 6, 0));
        pending_items.push_back(make_item(OP_RD_RHS, 1'b0, 0, 0, 0, 0, 0, 0, 32'h0, 63, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // sender holds off until every result of the directed part is back
        wait (pending_items.size() == 0 && !s_valid);
        @(posedge aclk);
        hold_sender <= 1'b1;
        wait (expected_results.size() == 0);
        @(posedge aclk);
        for (int i = 0; i < 1630; i++) pending_items.push_back(random_item());
        hold_sender <= 1'b0;

        wait (pending_items.size() == 0 && !s_valid);
        n = 0;
        while (expected_results.size() != 0 && n < 10000) begin
            @(posedge aclk);
            n++;
        end
        repeat (60) @(posedge aclk);
        if (failed || expected_results.size() != 0)
            $display("** mna_stamp_accumulator_core: FAILED **");
        else
            $display("** mna_stamp_accumulator_core: PASSED **");
        $finish;
    end

endmodule

>>> mna_stamp_accumulator_core.f
+incdir+rtl/core
rtl/core/msa_pkg.sv
rtl/core/msa_div.sv
rtl/core/msa_dp.sv
rtl/core/msa_ctrl.sv
rtl/core/mna_stamp_accumulator_core.sv
test/tb_mna_stamp_accumulator_core.sv
